// ----- src/pgp_pkg.sv -----
// Widths, constants and carried-data type for the pure-pursuit goal point pipeline.
package pgp_pkg;

   localparam int IN_W    = 20;  // field coordinates
   localparam int LK_W    = 19;  // lookahead radius
   localparam int REL_W   = 21;  // coordinates relative to the robot
   localparam int DEL_W   = 22;  // segment deltas
   localparam int DR2_W   = 44;  // squared segment length
   localparam int CR_W    = 42;  // cross term
   localparam int LK2_W   = 38;  // squared radius
   localparam int HALF_W  = 22;  // operand slice for partial products
   localparam int PROD_W  = 84;  // discriminant products
   localparam int ROOT_W  = 41;  // integer square root
   localparam int MAG_W   = 64;  // numerator term magnitudes
   localparam int TERM_W  = 65;  // signed numerator terms
   localparam int NUM_W   = 66;  // signed numerators
   localparam int Q_W     = 24;  // quotient magnitude
   localparam int QS_W    = 25;  // signed quotient
   localparam int REM_W   = 68;  // divider remainder
   localparam int OFF_W   = 26;  // offsets and bounds compares
   localparam int SQ_W    = 52;  // squared offsets
   localparam int DIST_W  = 53;  // squared distance to the end point
   localparam int GOAL_W  = 26;  // goal before saturation
   localparam int LANES   = 4;   // x minus, x plus, y minus, y plus

   localparam int LANE_X0 = 0;
   localparam int LANE_X1 = 1;
   localparam int LANE_Y0 = 2;
   localparam int LANE_Y1 = 3;

   localparam int LOOKAHEAD_INCHES = 10;

   localparam logic signed [GOAL_W-1:0] GOAL_MAX = GOAL_W'((64'sd1 <<< (IN_W - 1)) - 64'sd1);
   localparam logic signed [GOAL_W-1:0] GOAL_MIN = GOAL_W'(-(64'sd1 <<< (IN_W - 1)));

   typedef struct packed {
      logic signed [IN_W-1:0]  rx;
      logic signed [IN_W-1:0]  ry;
      logic signed [REL_W-1:0] sx;
      logic signed [REL_W-1:0] sy;
      logic signed [REL_W-1:0] ex;
      logic signed [REL_W-1:0] ey;
      logic signed [DEL_W-1:0] dx;
      logic signed [DEL_W-1:0] dy;
      logic [DEL_W-1:0]        adx;
      logic [DEL_W-1:0]        ady;
      logic [DR2_W-1:0]        dr2;
      logic signed [CR_W-1:0]  cr;
      logic [CR_W-1:0]         acr;
      logic                    hit;
   } side_type;

endpackage

// ----- src/pursuit_goal_point.sv -----
// Pure-pursuit goal point: line/circle intersection, pipelined root and dividers.
//
// Takes one request per clock cycle (busy is always low) and answers each with one
// result strobed on rsp_valid for a single cycle, in request order. The receiver
// cannot hold results off. The pipeline is built around the 41-stage square root
// (one root bit per stage) and the 24-stage restoring dividers (one quotient bit per
// stage, four lanes in parallel); the rest is fifteen stages of partial products,
// sums and selection. csr_wr_data sets the lookahead radius and should only be
// written while no request is in flight.
module pursuit_goal_point #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [pgp_pkg::IN_W-1:0]   req_robot_x,
   input  logic signed [pgp_pkg::IN_W-1:0]   req_robot_y,
   input  logic signed [pgp_pkg::IN_W-1:0]   req_start_x,
   input  logic signed [pgp_pkg::IN_W-1:0]   req_start_y,
   input  logic signed [pgp_pkg::IN_W-1:0]   req_end_x,
   input  logic signed [pgp_pkg::IN_W-1:0]   req_end_y,
   input  logic                              csr_wr_en,
   input  logic [pgp_pkg::LK_W-1:0]          csr_wr_data,
   output logic                              rsp_valid,
   output logic                              rsp_circle_hit,
   output logic                              rsp_found,
   output logic signed [pgp_pkg::IN_W-1:0]   rsp_goal_x,
   output logic signed [pgp_pkg::IN_W-1:0]   rsp_goal_y
);

   localparam int IN_W   = pgp_pkg::IN_W;
   localparam int LK_W   = pgp_pkg::LK_W;
   localparam int REL_W  = pgp_pkg::REL_W;
   localparam int DEL_W  = pgp_pkg::DEL_W;
   localparam int DR2_W  = pgp_pkg::DR2_W;
   localparam int CR_W   = pgp_pkg::CR_W;
   localparam int LK2_W  = pgp_pkg::LK2_W;
   localparam int HALF_W = pgp_pkg::HALF_W;
   localparam int PROD_W = pgp_pkg::PROD_W;
   localparam int ROOT_W = pgp_pkg::ROOT_W;
   localparam int MAG_W  = pgp_pkg::MAG_W;
   localparam int TERM_W = pgp_pkg::TERM_W;
   localparam int NUM_W  = pgp_pkg::NUM_W;
   localparam int Q_W    = pgp_pkg::Q_W;
   localparam int QS_W   = pgp_pkg::QS_W;
   localparam int REM_W  = pgp_pkg::REM_W;
   localparam int OFF_W  = pgp_pkg::OFF_W;
   localparam int SQ_W   = pgp_pkg::SQ_W;
   localparam int DIST_W = pgp_pkg::DIST_W;
   localparam int GOAL_W = pgp_pkg::GOAL_W;
   localparam int LANES  = pgp_pkg::LANES;
   localparam int LATENCY = 6 + ROOT_W + 4 + Q_W + 5;

   localparam int unsigned LK_FULL = pgp_pkg::LOOKAHEAD_INCHES << FRACTION_BITS;
   localparam logic [LK_W-1:0] LK_RESET = LK_FULL[LK_W-1:0];

   function automatic logic signed [TERM_W-1:0] apply_sign(input logic neg,
                                                           input logic [MAG_W-1:0] mag);
      logic signed [TERM_W-1:0] v;
      v = $signed({1'b0, mag});
      return neg ? -v : v;
   endfunction

   function automatic logic in_span(input logic signed [OFF_W-1:0] v,
                                    input logic signed [OFF_W-1:0] a,
                                    input logic signed [OFF_W-1:0] b);
      return (v >= a && v <= b) || (v >= b && v <= a);
   endfunction

   function automatic logic signed [IN_W-1:0] sat_goal(input logic signed [GOAL_W-1:0] v);
      logic signed [GOAL_W-1:0] c;
      c = v;
      if (v > pgp_pkg::GOAL_MAX) c = pgp_pkg::GOAL_MAX;
      if (v < pgp_pkg::GOAL_MIN) c = pgp_pkg::GOAL_MIN;
      return c[IN_W-1:0];
   endfunction

   // ---------------- configuration ----------------
   logic [LK_W-1:0] lk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lk_ff <= LK_RESET;
      end else if (csr_wr_en) begin
         lk_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // ---------------- stage A: relative coordinates ----------------
   logic              a_vld_ff;
   pgp_pkg::side_type a_side_in, a_side_ff;

   always_comb begin
      a_side_in    = '0;
      a_side_in.rx = req_robot_x;
      a_side_in.ry = req_robot_y;
      a_side_in.sx = REL_W'(req_start_x) - REL_W'(req_robot_x);
      a_side_in.sy = REL_W'(req_start_y) - REL_W'(req_robot_y);
      a_side_in.ex = REL_W'(req_end_x) - REL_W'(req_robot_x);
      a_side_in.ey = REL_W'(req_end_y) - REL_W'(req_robot_y);
      a_side_in.dx = DEL_W'(req_end_x) - DEL_W'(req_start_x);
      a_side_in.dy = DEL_W'(req_end_y) - DEL_W'(req_start_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_side_ff <= a_side_in;
   end

   // ---------------- stage B: small products ----------------
   logic                        b_vld_ff;
   pgp_pkg::side_type           b_side_in, b_side_ff;
   logic signed [2*DEL_W-1:0]   b_dxx_ff, b_dyy_ff;
   logic signed [2*REL_W-1:0]   b_p1_ff, b_p2_ff;
   logic [LK2_W-1:0]            b_lk2_ff;

   always_comb begin
      b_side_in     = a_side_ff;
      b_side_in.adx = a_side_ff.dx[DEL_W-1] ? DEL_W'(-a_side_ff.dx) : DEL_W'(a_side_ff.dx);
      b_side_in.ady = a_side_ff.dy[DEL_W-1] ? DEL_W'(-a_side_ff.dy) : DEL_W'(a_side_ff.dy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_side_ff <= b_side_in;
      b_dxx_ff  <= a_side_ff.dx * a_side_ff.dx;
      b_dyy_ff  <= a_side_ff.dy * a_side_ff.dy;
      b_p1_ff   <= a_side_ff.sx * a_side_ff.ey;
      b_p2_ff   <= a_side_ff.ex * a_side_ff.sy;
      b_lk2_ff  <= lk_ff * lk_ff;
   end

   // ---------------- stage C: dr2 and cross term ----------------
   logic              c_vld_ff;
   pgp_pkg::side_type c_side_in, c_side_ff;
   logic [LK2_W-1:0]  c_lk2_ff;
   logic signed [CR_W-1:0] c_cr;

   always_comb begin
      c_cr          = CR_W'(b_p1_ff) - CR_W'(b_p2_ff);
      c_side_in     = b_side_ff;
      c_side_in.dr2 = DR2_W'($unsigned(b_dxx_ff)) + DR2_W'($unsigned(b_dyy_ff));
      c_side_in.cr  = c_cr;
      c_side_in.acr = c_cr[CR_W-1] ? CR_W'(-c_cr) : CR_W'(c_cr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_side_ff <= c_side_in;
      c_lk2_ff  <= b_lk2_ff;
   end

   // ---------------- stage D: partial products of the discriminant ----------------
   logic                             d_vld_ff;
   pgp_pkg::side_type                d_side_ff;
   logic [2*HALF_W-1:0]              d_all_ff, d_alh_ff, d_cll_ff;
   logic [LK2_W-1:0]                 d_ahl_ff, d_ahh_ff;
   logic [CR_W-1:0]                  d_clh_ff;
   logic [2*(CR_W-HALF_W)-1:0]       d_chh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_side_ff <= c_side_ff;
      d_all_ff  <= c_lk2_ff[HALF_W-1:0] * c_side_ff.dr2[HALF_W-1:0];
      d_alh_ff  <= c_lk2_ff[HALF_W-1:0] * c_side_ff.dr2[DR2_W-1:HALF_W];
      d_ahl_ff  <= c_lk2_ff[LK2_W-1:HALF_W] * c_side_ff.dr2[HALF_W-1:0];
      d_ahh_ff  <= c_lk2_ff[LK2_W-1:HALF_W] * c_side_ff.dr2[DR2_W-1:HALF_W];
      d_cll_ff  <= c_side_ff.acr[HALF_W-1:0] * c_side_ff.acr[HALF_W-1:0];
      d_clh_ff  <= c_side_ff.acr[HALF_W-1:0] * c_side_ff.acr[CR_W-1:HALF_W];
      d_chh_ff  <= c_side_ff.acr[CR_W-1:HALF_W] * c_side_ff.acr[CR_W-1:HALF_W];
   end

   // ---------------- stage E: assemble lk^2*dr2 and cr^2 ----------------
   logic              e_vld_ff;
   pgp_pkg::side_type e_side_ff;
   logic [PROD_W-1:0] e_a_ff, e_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_side_ff <= d_side_ff;
      e_a_ff    <= PROD_W'(d_all_ff) + (PROD_W'(d_alh_ff) << HALF_W)
                 + (PROD_W'(d_ahl_ff) << HALF_W) + (PROD_W'(d_ahh_ff) << (2*HALF_W));
      // cross slice counted twice: shift one further
      e_b_ff    <= PROD_W'(d_cll_ff) + (PROD_W'(d_clh_ff) << (HALF_W + 1))
                 + (PROD_W'(d_chh_ff) << (2*HALF_W));
   end

   // ---------------- stage F and square root pipeline ----------------
   logic              sq_vld_ff  [ROOT_W+1];
   pgp_pkg::side_type sq_side_ff [ROOT_W+1];
   logic [PROD_W-1:0] sq_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] sq_res_ff  [ROOT_W+1];
   logic              f_hit;
   pgp_pkg::side_type f_side;

   assign f_hit = (e_side_ff.dr2 != '0) && (e_b_ff <= e_a_ff);

   always_comb begin
      f_side     = e_side_ff;
      f_side.hit = f_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_side_ff[0]     <= f_side;
      sq_rem_ff[0]      <= f_hit ? e_a_ff - e_b_ff : '0;
      sq_res_ff[0]      <= '0;
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      localparam int BIT = ROOT_W - 1 - i;
      logic [PROD_W-1:0] trial;

      // (res + 2^bit)^2 - res^2
      assign trial = (PROD_W'(sq_res_ff[i]) << (BIT + 1)) | (PROD_W'(1) << (2*BIT));

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[i+1] <= 1'b0;
         end else begin
            sq_vld_ff[i+1] <= sq_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         sq_side_ff[i+1] <= sq_side_ff[i];
         if (trial <= sq_rem_ff[i]) begin
            sq_rem_ff[i+1] <= sq_rem_ff[i] - trial;
            sq_res_ff[i+1] <= sq_res_ff[i] | (ROOT_W'(1) << BIT);
         end else begin
            sq_rem_ff[i+1] <= sq_rem_ff[i];
            sq_res_ff[i+1] <= sq_res_ff[i];
         end
      end
   end

   // ---------------- stage G: numerator partial products ----------------
   logic                           g_vld_ff;
   pgp_pkg::side_type              g_side_ff;
   logic [2*HALF_W-1:0]            g_cdy_l_ff, g_cdx_l_ff, g_xr_l_ff, g_yr_l_ff;
   logic [CR_W-1:0]                g_cdy_h_ff, g_cdx_h_ff;
   logic [ROOT_W-1:0]              g_xr_h_ff, g_yr_h_ff;
   pgp_pkg::side_type              g_src;
   logic [ROOT_W-1:0]              g_root;

   assign g_src  = sq_side_ff[ROOT_W];
   assign g_root = sq_res_ff[ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= sq_vld_ff[ROOT_W];
      end
   end

   always_ff @(posedge clock) begin
      g_side_ff  <= g_src;
      g_cdy_l_ff <= g_src.acr[HALF_W-1:0] * g_src.ady;
      g_cdy_h_ff <= g_src.acr[CR_W-1:HALF_W] * g_src.ady;
      g_cdx_l_ff <= g_src.acr[HALF_W-1:0] * g_src.adx;
      g_cdx_h_ff <= g_src.acr[CR_W-1:HALF_W] * g_src.adx;
      g_xr_l_ff  <= g_root[HALF_W-1:0] * g_src.adx;
      g_xr_h_ff  <= g_root[ROOT_W-1:HALF_W] * g_src.adx;
      g_yr_l_ff  <= g_root[HALF_W-1:0] * g_src.ady;
      g_yr_h_ff  <= g_root[ROOT_W-1:HALF_W] * g_src.ady;
   end

   // ---------------- stage H: signed terms ----------------
   logic                     h_vld_ff;
   pgp_pkg::side_type        h_side_ff;
   logic signed [TERM_W-1:0] h_t1_ff, h_t2_ff, h_t3_ff, h_t4_ff;
   logic [MAG_W-1:0]         h_m1, h_m2, h_m3, h_m4;
   logic                     h_scr, h_sdx, h_sdy;

   always_comb begin
      h_m1  = MAG_W'(g_cdy_l_ff) + (MAG_W'(g_cdy_h_ff) << HALF_W);
      h_m4  = MAG_W'(g_cdx_l_ff) + (MAG_W'(g_cdx_h_ff) << HALF_W);
      h_m2  = MAG_W'(g_xr_l_ff) + (MAG_W'(g_xr_h_ff) << HALF_W);
      h_m3  = MAG_W'(g_yr_l_ff) + (MAG_W'(g_yr_h_ff) << HALF_W);
      h_scr = g_side_ff.cr[CR_W-1];
      h_sdx = g_side_ff.dx[DEL_W-1];
      h_sdy = g_side_ff.dy[DEL_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      h_side_ff <= g_side_ff;
      h_t1_ff   <= apply_sign(h_scr ^ h_sdy, h_m1);      // cr*dy
      h_t2_ff   <= apply_sign(h_sdx ^ h_sdy, h_m2);      // sg*dx*root
      h_t3_ff   <= apply_sign(~(h_scr ^ h_sdx), h_m4);   // -cr*dx
      h_t4_ff   <= apply_sign(1'b0, h_m3);               // |dy|*root
   end

   // ---------------- stage I: numerators ----------------
   logic                    i_vld_ff;
   pgp_pkg::side_type       i_side_ff;
   logic signed [NUM_W-1:0] i_num_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else begin
         i_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      i_side_ff                  <= h_side_ff;
      i_num_ff[pgp_pkg::LANE_X0] <= NUM_W'(h_t1_ff) - NUM_W'(h_t2_ff);
      i_num_ff[pgp_pkg::LANE_X1] <= NUM_W'(h_t1_ff) + NUM_W'(h_t2_ff);
      i_num_ff[pgp_pkg::LANE_Y0] <= NUM_W'(h_t3_ff) - NUM_W'(h_t4_ff);
      i_num_ff[pgp_pkg::LANE_Y1] <= NUM_W'(h_t3_ff) + NUM_W'(h_t4_ff);
   end

   // ---------------- stage J and divider pipeline ----------------
   logic              dv_vld_ff  [Q_W+1];
   pgp_pkg::side_type dv_side_ff [Q_W+1];
   logic [REM_W-1:0]  dv_rem_ff  [Q_W+1][LANES];
   logic [Q_W-1:0]    dv_q_ff    [Q_W+1][LANES];
   logic              dv_neg_ff  [Q_W+1][LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else begin
         dv_vld_ff[0] <= i_vld_ff;
      end
   end

   // divide magnitudes, sign restored afterwards: truncation toward zero
   always_ff @(posedge clock) begin
      dv_side_ff[0] <= i_side_ff;
      for (int k = 0; k < LANES; k++) begin
         dv_neg_ff[0][k] <= i_num_ff[k][NUM_W-1];
         dv_rem_ff[0][k] <= i_num_ff[k][NUM_W-1] ? REM_W'($unsigned(-i_num_ff[k]))
                                                 : REM_W'($unsigned(i_num_ff[k]));
         dv_q_ff[0][k]   <= '0;
      end
   end

   for (genvar i = 0; i < Q_W; i++) begin : g_div
      localparam int BIT = Q_W - 1 - i;
      logic [REM_W-1:0] shifted;

      assign shifted = REM_W'(dv_side_ff[i].dr2) << BIT;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[i+1] <= 1'b0;
         end else begin
            dv_vld_ff[i+1] <= dv_vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         dv_side_ff[i+1] <= dv_side_ff[i];
         for (int k = 0; k < LANES; k++) begin
            dv_neg_ff[i+1][k] <= dv_neg_ff[i][k];
            if (shifted <= dv_rem_ff[i][k]) begin
               dv_rem_ff[i+1][k] <= dv_rem_ff[i][k] - shifted;
               dv_q_ff[i+1][k]   <= dv_q_ff[i][k] | (Q_W'(1) << BIT);
            end else begin
               dv_rem_ff[i+1][k] <= dv_rem_ff[i][k];
               dv_q_ff[i+1][k]   <= dv_q_ff[i][k];
            end
         end
      end
   end

   // ---------------- stage K: signed solutions ----------------
   logic                    k_vld_ff;
   pgp_pkg::side_type       k_side_ff;
   logic signed [QS_W-1:0]  k_sol_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         k_vld_ff <= 1'b0;
      end else begin
         k_vld_ff <= dv_vld_ff[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      k_side_ff <= dv_side_ff[Q_W];
      for (int k = 0; k < LANES; k++) begin
         k_sol_ff[k] <= dv_neg_ff[Q_W][k] ? -$signed({1'b0, dv_q_ff[Q_W][k]})
                                          : $signed({1'b0, dv_q_ff[Q_W][k]});
      end
   end

   // ---------------- stage L: bounding box and offsets to the end point ----------------
   logic                    l_vld_ff;
   pgp_pkg::side_type       l_side_ff;
   logic signed [QS_W-1:0]  l_px_ff [2];
   logic signed [QS_W-1:0]  l_py_ff [2];
   logic signed [OFF_W-1:0] l_qx_ff [2];
   logic signed [OFF_W-1:0] l_qy_ff [2];
   logic                    l_ok_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         l_vld_ff <= 1'b0;
      end else begin
         l_vld_ff <= k_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      l_side_ff <= k_side_ff;
      for (int j = 0; j < 2; j++) begin
         l_px_ff[j] <= k_sol_ff[pgp_pkg::LANE_X0 + j];
         l_py_ff[j] <= k_sol_ff[pgp_pkg::LANE_Y0 + j];
         l_qx_ff[j] <= OFF_W'(k_sol_ff[pgp_pkg::LANE_X0 + j]) - OFF_W'(k_side_ff.ex);
         l_qy_ff[j] <= OFF_W'(k_sol_ff[pgp_pkg::LANE_Y0 + j]) - OFF_W'(k_side_ff.ey);
         l_ok_ff[j] <= in_span(OFF_W'(k_sol_ff[pgp_pkg::LANE_X0 + j]),
                               OFF_W'(k_side_ff.sx), OFF_W'(k_side_ff.ex))
                    && in_span(OFF_W'(k_sol_ff[pgp_pkg::LANE_Y0 + j]),
                               OFF_W'(k_side_ff.sy), OFF_W'(k_side_ff.ey));
      end
   end

   // ---------------- stage M: squared offsets ----------------
   logic                    m_vld_ff;
   pgp_pkg::side_type       m_side_ff;
   logic signed [QS_W-1:0]  m_px_ff [2];
   logic signed [QS_W-1:0]  m_py_ff [2];
   logic signed [SQ_W-1:0]  m_sqx_ff [2];
   logic signed [SQ_W-1:0]  m_sqy_ff [2];
   logic                    m_ok_ff [2];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= l_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      m_side_ff <= l_side_ff;
      for (int j = 0; j < 2; j++) begin
         m_px_ff[j]  <= l_px_ff[j];
         m_py_ff[j]  <= l_py_ff[j];
         m_ok_ff[j]  <= l_ok_ff[j];
         m_sqx_ff[j] <= l_qx_ff[j] * l_qx_ff[j];
         m_sqy_ff[j] <= l_qy_ff[j] * l_qy_ff[j];
      end
   end

   // ---------------- stage N: choose the solution ----------------
   logic                   n_vld_ff;
   pgp_pkg::side_type      n_side_ff;
   logic signed [QS_W-1:0] n_px_ff, n_py_ff;
   logic                   n_found_ff;
   logic [DIST_W-1:0]      n_dist0, n_dist1;
   logic                   n_sel1;

   always_comb begin
      n_dist0 = DIST_W'($unsigned(m_sqx_ff[0])) + DIST_W'($unsigned(m_sqy_ff[0]));
      n_dist1 = DIST_W'($unsigned(m_sqx_ff[1])) + DIST_W'($unsigned(m_sqy_ff[1]));
      // a tie keeps the minus solution
      n_sel1  = m_ok_ff[1] && (!m_ok_ff[0] || (n_dist1 < n_dist0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff <= 1'b0;
      end else begin
         n_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_side_ff  <= m_side_ff;
      n_found_ff <= m_side_ff.hit && (m_ok_ff[0] || m_ok_ff[1]);
      n_px_ff    <= n_sel1 ? m_px_ff[1] : m_px_ff[0];
      n_py_ff    <= n_sel1 ? m_py_ff[1] : m_py_ff[0];
   end

   // ---------------- stage O: back to field coordinates, result register ----------------
   logic signed [GOAL_W-1:0] o_gx, o_gy;

   assign o_gx = GOAL_W'(n_px_ff) + GOAL_W'(n_side_ff.rx);
   assign o_gy = GOAL_W'(n_py_ff) + GOAL_W'(n_side_ff.ry);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= n_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_circle_hit <= n_side_ff.hit;
      rsp_found      <= n_found_ff;
      rsp_goal_x     <= n_found_ff ? sat_goal(o_gx) : '0;
      rsp_goal_y     <= n_found_ff ? sat_goal(o_gy) : '0;
   end

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff |-> ##(LATENCY - 1) rsp_valid)
      else $error("request lost in pipeline");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      sq_vld_ff[ROOT_W] |->
         sq_rem_ff[ROOT_W] <= (PROD_W'(sq_res_ff[ROOT_W]) << 1))
      else $error("square root remainder too large");

   a_quotient_fits: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[Q_W] && dv_side_ff[Q_W].hit |->
         dv_rem_ff[Q_W][pgp_pkg::LANE_X0] < REM_W'(dv_side_ff[Q_W].dr2)
         && dv_rem_ff[Q_W][pgp_pkg::LANE_X1] < REM_W'(dv_side_ff[Q_W].dr2)
         && dv_rem_ff[Q_W][pgp_pkg::LANE_Y0] < REM_W'(dv_side_ff[Q_W].dr2)
         && dv_rem_ff[Q_W][pgp_pkg::LANE_Y1] < REM_W'(dv_side_ff[Q_W].dr2))
      else $error("quotient overflow in divider");

   a_found_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_circle_hit)
      else $error("goal found without circle hit");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_goal_x == '0 && rsp_goal_y == '0)
      else $error("goal not cleared when none found");
`endif

endmodule

// ----- sim/tb_pursuit_goal_point.sv -----
// Self-checking testbench for the pure-pursuit goal point block.
module tb_pursuit_goal_point;

   localparam int IN_W   = pgp_pkg::IN_W;
   localparam int LK_W   = pgp_pkg::LK_W;
   localparam int ROOT_W = pgp_pkg::ROOT_W;
   localparam int PROD_W = pgp_pkg::PROD_W;

   localparam int FB = 8;
   localparam int LATENCY = 80;

   typedef struct {
      logic signed [IN_W-1:0] rx, ry, sx, sy, ex, ey;
   } seg_type;

   typedef struct {
      logic                   hit;
      logic                   found;
      logic signed [IN_W-1:0] gx, gy;
   } goal_type;

   int n_err;

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      n_err++;
   endtask

   // integer square root of an 84-bit value, one bit at a time
   function automatic logic [ROOT_W-1:0] sqrt84(input logic [PROD_W-1:0] v);
      logic [ROOT_W-1:0] r;
      logic [ROOT_W-1:0] c;
      r = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         c = r | (ROOT_W'(1) << b);
         if ((PROD_W'(c) * PROD_W'(c)) <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [IN_W-1:0] clamp20(input longint v);
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return IN_W'(v);
   endfunction

   function automatic goal_type goal_point(input seg_type s, input logic [LK_W-1:0] radius);
      goal_type g;
      longint sx, sy, ex, ey, dx, dy, dr2, cr, ady, sg, rt;
      logic signed [127:0] a, b, num;
      longint px[2], py[2];
      logic [127:0] dsq[2];
      bit ok[2];
      int pick;
      g = '{default: 0};
      sx = longint'(s.sx) - s.rx; sy = longint'(s.sy) - s.ry;
      ex = longint'(s.ex) - s.rx; ey = longint'(s.ey) - s.ry;
      dx = ex - sx; dy = ey - sy;
      dr2 = dx * dx + dy * dy;
      if (dr2 == 0) return g;
      cr = sx * ey - ex * sy;
      a = 128'(radius) * 128'(radius) * 128'(dr2);
      b = 128'(cr) * 128'(cr);
      if (b > a) return g;
      g.hit = 1;
      rt = longint'(sqrt84(PROD_W'(a - b)));
      sg = dy < 0 ? -1 : 1;
      ady = dy < 0 ? -dy : dy;
      for (int k = 0; k < 2; k++) begin
         num = 128'(cr) * dy + (k ? 1 : -1) * 128'(sg * dx) * rt;
         px[k] = longint'(num / dr2);
         num = -128'(cr) * dx + (k ? 1 : -1) * 128'(ady) * rt;
         py[k] = longint'(num / dr2);
         ok[k] = px[k] >= (sx < ex ? sx : ex) && px[k] <= (sx < ex ? ex : sx) &&
                 py[k] >= (sy < ey ? sy : ey) && py[k] <= (sy < ey ? ey : sy);
         dsq[k] = 128'((px[k] - ex) * (px[k] - ex)) + 128'((py[k] - ey) * (py[k] - ey));
      end
      if (ok[0] && ok[1]) pick = dsq[1] < dsq[0] ? 1 : 0;
      else if (ok[0]) pick = 0;
      else if (ok[1]) pick = 1;
      else return g;
      g.found = 1;
      g.gx = clamp20(px[pick] + s.rx);
      g.gy = clamp20(py[pick] + s.ry);
      return g;
   endfunction

   class goal_board_type;
      goal_type pending[$];
      logic [LK_W-1:0] radius;
      int n_checked, n_found;

      function void note_request(input seg_type s);
         pending.push_back(goal_point(s, radius));
      endfunction

      task check_result(input goal_type got);
         goal_type w;
         if (pending.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         w = pending.pop_front();
         n_checked++;
         if (w.found) n_found++;
         if (got.hit !== w.hit) report("circle_hit", got.hit, w.hit);
         if (got.found !== w.found) report("found", got.found, w.found);
         if (got.gx !== w.gx) report("goal_x", got.gx, w.gx);
         if (got.gy !== w.gy) report("goal_y", got.gy, w.gy);
      endtask
   endclass

   logic clock = 0, reset = 1, start = 0, busy;
   logic signed [IN_W-1:0] rx = 0, ry = 0, sx = 0, sy = 0, ex = 0, ey = 0;
   logic csr_wr_en = 0;
   logic [LK_W-1:0] csr_wr_data = 0;
   logic rsp_valid, rsp_circle_hit, rsp_found;
   logic signed [IN_W-1:0] rsp_goal_x, rsp_goal_y;
   goal_board_type board;
   bit quiet;

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   pursuit_goal_point #(.FRACTION_BITS(FB)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_robot_x(rx), .req_robot_y(ry), .req_start_x(sx), .req_start_y(sy),
      .req_end_x(ex), .req_end_y(ey),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_circle_hit(rsp_circle_hit), .rsp_found(rsp_found),
      .rsp_goal_x(rsp_goal_x), .rsp_goal_y(rsp_goal_y)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result('{rsp_circle_hit, rsp_found, rsp_goal_x, rsp_goal_y});
   end

   // drives one request; returns at the falling edge after it was taken
   task automatic send_request(input seg_type s);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start <= 1;
      {rx, ry, sx, sy, ex, ey} <= {s.rx, s.ry, s.sx, s.sy, s.ex, s.ey};
      do @(posedge clock); while (busy);
      board.note_request(s);
      @(negedge clock);
   endtask

   task automatic set_radius(input logic [LK_W-1:0] v);
      start <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      board.radius = v;
   endtask

   function automatic logic signed [IN_W-1:0] rnd20();
      return IN_W'($urandom);
   endfunction

   function automatic logic signed [IN_W-1:0] near(input logic signed [IN_W-1:0] c,
                                                   input int span);
      return IN_W'(longint'(c) + $urandom_range(0, 2 * span) - span);
   endfunction

   // mostly segments that pass close to the circle, some anywhere
   function automatic seg_type rand_segment(input logic [LK_W-1:0] r);
      seg_type s;
      int span;
      span = r + 64;
      s.rx = $urandom_range(0, 9) == 0 ? rnd20() : IN_W'($urandom_range(0, 8191) - 4096);
      s.ry = $urandom_range(0, 9) == 0 ? rnd20() : IN_W'($urandom_range(0, 8191) - 4096);
      case ($urandom_range(0, 5))
         0: {s.sx, s.sy, s.ex, s.ey} = {rnd20(), rnd20(), rnd20(), rnd20()};
         1: begin
            s.sx = near(s.rx, span); s.sy = near(s.ry, span);
            s.ex = s.sx; s.ey = s.sy;
         end
         default: begin
            s.sx = near(s.rx, 2 * span); s.sy = near(s.ry, 2 * span);
            s.ex = near(s.rx, 2 * span); s.ey = near(s.ry, 2 * span);
         end
      endcase
      return s;
   endfunction

   logic [LK_W-1:0] radii[6] = '{19'd2560, 19'd0, 19'd524287, 19'd1, 19'd777, 19'd40000};
   seg_type directed[$];

   initial begin
      board = new();
      board.radius = 19'd2560;
      quiet = 0;
      repeat (6) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // reset radius: straight lines across, tangent, miss, zero length, extremes
      directed = '{
         '{0, 0, -5120, 0, 5120, 0}, '{0, 0, 0, -5120, 0, 5120},
         '{0, 0, -5120, 2560, 5120, 2560}, '{0, 0, -5120, 2561, 5120, 2561},
         '{0, 0, 0, 0, 1000, 0}, '{0, 0, 100, 100, 100, 100},
         '{0, 0, 5120, 5120, -5120, -5120}, '{0, 0, 5120, -5120, -5120, 5120},
         '{0, 0, -1000, 0, 1000, 0}, '{100, -200, 100, -200, 5000, 300},
         '{-524288, -524288, -524288, -524288, 524287, 524287},
         '{524287, 524287, 524287, -524288, -524288, 524287},
         '{524287, -524288, -524288, 524287, 524287, -524288},
         '{-524288, 524287, -524288, -524288, -524288, 524287},
         '{0, 0, -524288, 0, 524287, 0}};
      foreach (directed[i]) send_request(directed[i]);
      set_radius(19'd524287);
      send_request('{524287, 0, -524288, 0, 524287, 0});
      send_request('{0, 0, -524288, -524288, 524287, 524287});
      send_request('{-524288, 524287, 524287, -524288, -524288, -524288});
      send_request('{0, 0, 0, 0, 0, 0});
      for (int p = 0; p < 6; p++) begin
         set_radius(radii[p]);
         for (int i = 0; i < 175; i++) begin
            quiet = p == 5 && i > 120;
            send_request(rand_segment(radii[p]));
         end
      end
      start <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("checked %0d results over %0d radius settings, %0d with a goal point",
               board.n_checked, 8, board.n_found);
      if (n_err == 0 && board.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #400000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

// ----- sim.f -----
src/pgp_pkg.sv
src/pursuit_goal_point.sv
sim/tb_pursuit_goal_point.sv
